// ----- design/pdc_pkg.sv -----
`default_nettype none

package pdc_pkg;

   localparam int READING_BITS   = 14;
   localparam int PH_FRAC_BITS   = 8;
   localparam int PH_BITS        = 14;
   localparam int SUM_BITS       = READING_BITS + 8;
   localparam int OFFSET_BITS    = 16;
   localparam int SLOPE_BITS     = 12;
   localparam int PH_CFG_BITS    = 12;
   localparam int WINDOW_BITS    = 11;
   localparam int LOCK_TICK_BITS = 16;
   localparam int LOCK_BITS      = 17;
   localparam int COUNT_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DIV_BITS       = 24;
   localparam int DIVISOR_BITS   = 12;
   localparam int DIV_STEP_BITS  = 5;

   localparam logic [OFFSET_BITS-1:0]    BIAS_RESET_DEFAULT  = 16'd4695;
   localparam logic [SLOPE_BITS-1:0]     SLOPE_DEFAULT       = 12'd450;
   localparam logic [PH_CFG_BITS-1:0]    CAL_POINT_DEFAULT   = 12'd1792;
   localparam logic [PH_CFG_BITS-1:0]    SET_POINT_DEFAULT   = 12'd1485;
   localparam logic [WINDOW_BITS-1:0]    WINDOW_DEFAULT      = 11'd128;
   localparam logic [LOCK_TICK_BITS-1:0] LOCK_TICKS_DEFAULT  = 16'd60000;
   localparam logic [COUNT_BITS-1:0]     AVG_COUNT_DEFAULT   = 8'd10;

   localparam logic [LOCK_BITS-1:0]      LOCK_MAX    = {LOCK_BITS{1'b1}};
   localparam logic [DIV_BITS-1:0]       PH_POS_MAX  = 24'd8191;
   localparam logic [DIV_BITS-1:0]       PH_NEG_MAX  = 24'd8192;
   localparam logic [PH_BITS-1:0]        PH_SAT_HIGH = 14'h1FFF;
   localparam logic [PH_BITS-1:0]        PH_SAT_LOW  = 14'h2000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIAS_RESET    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOPE         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_POINT     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SET_POINT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOCKOUT_TICKS = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AVG_COUNT     = 3'd6;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_RAISE = 2'd1;
   localparam logic [1:0] MODE_LOWER = 2'd2;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_TICK      = 2'd1,
      OP_CALIBRATE = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PH_WAIT,
      ST_AVG_CHECK,
      ST_AVG_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic ph_start;
      logic ph_write;
      logic avg_start;
      logic avg_write;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   changed;
      logic   avg_due;
      logic   div_done;
   } status_type;

endpackage

`default_nettype wire

// ----- design/ph_dosing_controller_top.sv -----
// pH dosing controller. One word in gives one word out, carrying the state left after
// it. A tick, calibrate or no-op goes from decode straight to the result register; a
// sample with a changed reading first runs a division for the pH value, and the end
// of an averaging window adds another division for the average. Both divisions share
// one restoring divider that retires one quotient bit per cycle over 24 bits. A new
// word is taken while the previous result is still waiting in the output register.
// The register port is always ready and may be written only while the block is idle.
`default_nettype none

module ph_dosing_controller_top import pdc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_op,
   input  logic [READING_BITS-1:0]   req_raw_reading,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PH_BITS-1:0] rsp_ph_value,
   output logic                      rsp_acid_pump,
   output logic                      rsp_base_pump,
   output logic [1:0]                rsp_dosing_mode,
   output logic                      rsp_lockout_active,
   output logic [READING_BITS-1:0]   rsp_average_reading,
   output logic [OFFSET_BITS-1:0]    rsp_offset_now
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_op              (req_op),
      .req_raw_reading     (req_raw_reading),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ph_value        (rsp_ph_value),
      .rsp_acid_pump       (rsp_acid_pump),
      .rsp_base_pump       (rsp_base_pump),
      .rsp_dosing_mode     (rsp_dosing_mode),
      .rsp_lockout_active  (rsp_lockout_active),
      .rsp_average_reading (rsp_average_reading),
      .rsp_offset_now      (rsp_offset_now)
   );

endmodule

`default_nettype wire

// ----- design/pdc_div.sv -----
`default_nettype none

module pdc_div import pdc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_BITS-1:0]     dividend,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output logic                    done,
   output logic [DIV_BITS-1:0]     quotient
);

   localparam logic [DIV_STEP_BITS-1:0] DIV_LAST = DIV_STEP_BITS'(DIV_BITS - 1);

   logic [DIV_BITS-1:0]     quot_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] dvs_ff;
   logic [DIV_STEP_BITS-1:0] step_ff;
   logic                    run_ff;
   logic                    done_ff;

   logic [DIVISOR_BITS:0]   rem_shift;
   logic [DIVISOR_BITS:0]   rem_diff;
   logic                    fits;
   logic [DIVISOR_BITS-1:0] rem_in;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIV_BITS-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_in    = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= DIV_LAST;
         end else if (run_ff) begin
            if (step_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (run_ff) begin
         quot_ff <= {quot_ff[DIV_BITS-2:0], fits};
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- design/pdc_datapath.sv -----
`default_nettype none

module pdc_datapath import pdc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic [1:0]                req_op,
   input  logic [READING_BITS-1:0]   req_raw_reading,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic signed [PH_BITS-1:0] rsp_ph_value,
   output logic                      rsp_acid_pump,
   output logic                      rsp_base_pump,
   output logic [1:0]                rsp_dosing_mode,
   output logic                      rsp_lockout_active,
   output logic [READING_BITS-1:0]   rsp_average_reading,
   output logic [OFFSET_BITS-1:0]    rsp_offset_now
);

   // configuration
   logic [SLOPE_BITS-1:0]     slope_ff;
   logic [PH_CFG_BITS-1:0]    cal_point_ff;
   logic [PH_CFG_BITS-1:0]    set_point_ff;
   logic [WINDOW_BITS-1:0]    window_ff;
   logic [LOCK_TICK_BITS-1:0] lock_ticks_ff;
   logic [COUNT_BITS-1:0]     avg_count_ff;

   // controller state
   logic [OFFSET_BITS-1:0]    offset_ff;
   logic signed [PH_BITS-1:0] ph_ff;
   logic [READING_BITS-1:0]   prev_ff;
   logic [SUM_BITS-1:0]       sum_ff;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [READING_BITS-1:0]   avg_ff;
   logic [LOCK_BITS-1:0]      lock_cnt_ff;
   logic                      expired_ff;
   logic                      raise_ff;
   logic                      lower_ff;
   logic                      acid_ff;
   logic                      base_ff;
   logic                      avg_due_ff;

   // item under work
   op_type                    op_ff;
   logic [READING_BITS-1:0]   reading_ff;
   logic                      ph_neg_ff;

   logic [LOCK_BITS-1:0]      lock_cnt_in;
   logic                      expired_in;
   logic                      raise_in;
   logic                      lower_in;
   logic                      acid_in;
   logic                      base_in;

   logic signed [15:0]        ph_w;
   logic signed [15:0]        sp_w;
   logic signed [15:0]        half_w;
   logic                      below;
   logic                      above;

   logic                      changed;
   logic [SUM_BITS-1:0]       sum_plus;
   logic [COUNT_BITS:0]       count_p1;
   logic [COUNT_BITS-1:0]     cnt_eff;
   logic                      due;
   logic [SLOPE_BITS-1:0]     slope_eff;

   logic [OFFSET_BITS+1:0]    ph_diff;
   logic [OFFSET_BITS+1:0]    ph_mag;
   logic [DIV_BITS-1:0]       quot;
   logic                      div_done;
   logic                      div_start;
   logic [DIV_BITS-1:0]       div_dividend;
   logic [DIVISOR_BITS-1:0]   div_divisor;
   logic [PH_BITS-1:0]        ph_sat;

   logic [2*PH_CFG_BITS-1:0]  cal_prod;
   logic [OFFSET_BITS:0]      cal_sum;
   logic [OFFSET_BITS-1:0]    cal_offset;

   always_comb begin
      ph_w   = 16'(ph_ff);
      sp_w   = $signed({4'b0, set_point_ff});
      half_w = $signed({6'b0, window_ff[WINDOW_BITS-1:1]});
      below  = ph_w < (sp_w - half_w);
      above  = ph_w > (sp_w + half_w);

      lock_cnt_in = lock_cnt_ff;
      expired_in  = expired_ff;
      raise_in    = raise_ff;
      lower_in    = lower_ff;
      acid_in     = acid_ff;
      base_in     = base_ff;
      if (below && expired_ff) begin
         expired_in  = 1'b0;
         lock_cnt_in = '0;
         raise_in    = 1'b1;
         lower_in    = 1'b0;
         base_in     = 1'b1;
      end else if (above && expired_ff) begin
         expired_in  = 1'b0;
         lock_cnt_in = '0;
         raise_in    = 1'b0;
         lower_in    = 1'b1;
         acid_in     = 1'b1;
      end
      if ((lower_in && (ph_w < sp_w)) || (raise_in && (ph_w > sp_w))) begin
         raise_in = 1'b0;
         lower_in = 1'b0;
         acid_in  = 1'b0;
         base_in  = 1'b0;
      end
   end

   always_comb begin
      changed   = reading_ff != prev_ff;
      sum_plus  = sum_ff + {{(SUM_BITS-READING_BITS){1'b0}}, reading_ff};
      count_p1  = {1'b0, count_ff} + 1'b1;
      cnt_eff   = (avg_count_ff == '0) ? COUNT_BITS'(1) : avg_count_ff;
      due       = count_p1 >= {1'b0, cnt_eff};
      slope_eff = (slope_ff == '0) ? SLOPE_BITS'(1) : slope_ff;

      ph_diff   = {2'b00, offset_ff} - {4'b0000, reading_ff};
      ph_mag    = ph_diff[OFFSET_BITS+1] ? (~ph_diff + 1'b1) : ph_diff;

      div_start    = cmd.ph_start | cmd.avg_start;
      div_dividend = cmd.ph_start ? {ph_mag[OFFSET_BITS-1:0], {PH_FRAC_BITS{1'b0}}}
                                  : {{(DIV_BITS-SUM_BITS){1'b0}}, sum_ff};
      div_divisor  = cmd.ph_start ? slope_eff
                                  : {{(DIVISOR_BITS-COUNT_BITS){1'b0}}, cnt_eff};

      if (!ph_neg_ff) begin
         ph_sat = (quot > PH_POS_MAX) ? PH_SAT_HIGH : quot[PH_BITS-1:0];
      end else begin
         ph_sat = (quot > PH_NEG_MAX) ? PH_SAT_LOW : (~quot[PH_BITS-1:0] + 1'b1);
      end

      cal_prod   = {{PH_CFG_BITS{1'b0}}, cal_point_ff} * {{PH_CFG_BITS{1'b0}}, slope_ff};
      cal_sum    = {1'b0, cal_prod[2*PH_CFG_BITS-1:8]} + {3'b000, avg_ff};
      cal_offset = cal_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : cal_sum[OFFSET_BITS-1:0];
   end

   pdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff      <= SLOPE_DEFAULT;
         cal_point_ff  <= CAL_POINT_DEFAULT;
         set_point_ff  <= SET_POINT_DEFAULT;
         window_ff     <= WINDOW_DEFAULT;
         lock_ticks_ff <= LOCK_TICKS_DEFAULT;
         avg_count_ff  <= AVG_COUNT_DEFAULT;
         offset_ff     <= BIAS_RESET_DEFAULT;
         ph_ff         <= '0;
         prev_ff       <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         avg_ff        <= '0;
         lock_cnt_ff   <= '0;
         expired_ff    <= 1'b1;
         raise_ff      <= 1'b0;
         lower_ff      <= 1'b0;
         acid_ff       <= 1'b0;
         base_ff       <= 1'b0;
         avg_due_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BIAS_RESET:    offset_ff     <= csr_data;
               CSR_SLOPE:         slope_ff      <= csr_data[SLOPE_BITS-1:0];
               CSR_CAL_POINT:     cal_point_ff  <= csr_data[PH_CFG_BITS-1:0];
               CSR_SET_POINT:     set_point_ff  <= csr_data[PH_CFG_BITS-1:0];
               CSR_WINDOW:        window_ff     <= csr_data[WINDOW_BITS-1:0];
               CSR_LOCKOUT_TICKS: lock_ticks_ff <= csr_data[LOCK_TICK_BITS-1:0];
               CSR_AVG_COUNT:     avg_count_ff  <= csr_data[COUNT_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.decode) begin
            unique case (op_ff)
               OP_SAMPLE: begin
                  lock_cnt_ff <= lock_cnt_in;
                  expired_ff  <= expired_in;
                  raise_ff    <= raise_in;
                  lower_ff    <= lower_in;
                  acid_ff     <= acid_in;
                  base_ff     <= base_in;
                  prev_ff     <= reading_ff;
                  if (changed) begin
                     sum_ff <= sum_plus;
                  end
                  count_ff   <= due ? '0 : count_p1[COUNT_BITS-1:0];
                  avg_due_ff <= due;
               end
               OP_TICK: begin
                  if ((lock_cnt_ff >= {1'b0, lock_ticks_ff}) && !expired_ff) begin
                     expired_ff <= 1'b1;
                  end else if (lock_cnt_ff != LOCK_MAX) begin
                     lock_cnt_ff <= lock_cnt_ff + 1'b1;
                  end
               end
               OP_CALIBRATE: offset_ff <= cal_offset;
               OP_NOP: ;
            endcase
         end
         if (cmd.ph_write) begin
            ph_ff <= ph_sat;
         end
         if (cmd.avg_start) begin
            sum_ff <= '0;
         end
         if (cmd.avg_write) begin
            avg_ff <= quot[READING_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_type'(req_op);
         reading_ff <= req_raw_reading;
      end
      if (cmd.ph_start) begin
         ph_neg_ff <= ph_diff[OFFSET_BITS+1];
      end
      if (cmd.rsp_load) begin
         rsp_ph_value        <= ph_ff;
         rsp_acid_pump       <= acid_ff;
         rsp_base_pump       <= base_ff;
         rsp_dosing_mode     <= raise_ff ? MODE_RAISE : (lower_ff ? MODE_LOWER : MODE_IDLE);
         rsp_lockout_active  <= !expired_ff;
         rsp_average_reading <= avg_ff;
         rsp_offset_now      <= offset_ff;
      end
   end

   always_comb begin
      status.op       = op_ff;
      status.changed  = changed;
      status.avg_due  = avg_due_ff;
      status.div_done = div_done;
   end

endmodule

`default_nettype wire

// ----- design/pdc_ctrl.sv -----
`default_nettype none

module pdc_ctrl import pdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.op != OP_SAMPLE) begin
               state_in = ST_FINISH;
            end else if (status.changed) begin
               cmd.ph_start = 1'b1;
               state_in     = ST_PH_WAIT;
            end else begin
               state_in = ST_AVG_CHECK;
            end
         end
         ST_PH_WAIT: begin
            if (status.div_done) begin
               cmd.ph_write = 1'b1;
               state_in     = ST_AVG_CHECK;
            end
         end
         ST_AVG_CHECK: begin
            if (status.avg_due) begin
               cmd.avg_start = 1'b1;
               state_in      = ST_AVG_WAIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.avg_write = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/pdc_checker.sv -----
`default_nettype none

module pdc_checker import pdc_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [PH_BITS-1:0] rsp_ph_value,
   input logic                      rsp_acid_pump,
   input logic                      rsp_base_pump,
   input logic [1:0]                rsp_dosing_mode,
   input logic [OFFSET_BITS-1:0]    rsp_offset_now
);

   // one word at a time in the datapath
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while previous word in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ph_value)
         && $stable(rsp_offset_now) && $stable(rsp_dosing_mode))
      else $error("stalled result word changed");

   a_raise_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dosing_mode == MODE_RAISE) |-> rsp_base_pump)
      else $error("raising without base pump");

   a_lower_acid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_dosing_mode == MODE_LOWER) |-> rsp_acid_pump)
      else $error("lowering without acid pump");

endmodule

bind ph_dosing_controller_top pdc_checker u_pdc_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pdc_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int LOCK_CEILING = (1 << LOCK_BITS) - 1;
   localparam int READING_MAX  = (1 << READING_BITS) - 1;

   typedef struct packed {
      logic signed [PH_BITS-1:0] ph;
      logic                      acid;
      logic                      base;
      logic [1:0]                mode;
      logic                      lock;
      logic [READING_BITS-1:0]   avg;
      logic [OFFSET_BITS-1:0]    offset;
   } dose_word_type;

   class dosing_scoreboard;
      int bias_cfg, slope_cfg, cal_cfg, set_cfg, window_cfg, lock_ticks_cfg, avg_cfg;
      int offset, ph_now, last_reading, sample_count, average, lock_count;
      logic [SUM_BITS-1:0] reading_sum;
      bit expired, raising, lowering, acid_on, base_on;
      dose_word_type due[$];
      int errors;

      function new();
         bias_cfg       = BIAS_RESET_DEFAULT;
         slope_cfg      = SLOPE_DEFAULT;
         cal_cfg        = CAL_POINT_DEFAULT;
         set_cfg        = SET_POINT_DEFAULT;
         window_cfg     = WINDOW_DEFAULT;
         lock_ticks_cfg = LOCK_TICKS_DEFAULT;
         avg_cfg        = AVG_COUNT_DEFAULT;
         offset         = BIAS_RESET_DEFAULT;
         ph_now         = 0;
         last_reading   = 0;
         sample_count   = 0;
         average        = 0;
         lock_count     = 0;
         reading_sum    = '0;
         expired        = 1'b1;
         raising        = 1'b0;
         lowering       = 1'b0;
         acid_on        = 1'b0;
         base_on        = 1'b0;
         errors         = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_BIAS_RESET: begin
               bias_cfg = data;
               offset   = data;
            end
            CSR_SLOPE:         slope_cfg      = data[SLOPE_BITS-1:0];
            CSR_CAL_POINT:     cal_cfg        = data[PH_CFG_BITS-1:0];
            CSR_SET_POINT:     set_cfg        = data[PH_CFG_BITS-1:0];
            CSR_WINDOW:        window_cfg     = data[WINDOW_BITS-1:0];
            CSR_LOCKOUT_TICKS: lock_ticks_cfg = data[LOCK_TICK_BITS-1:0];
            CSR_AVG_COUNT:     avg_cfg        = data[COUNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void start_pump(bit raise);
         if (!expired) return;
         expired    = 1'b0;
         lock_count = 0;
         raising    = raise;
         lowering   = !raise;
         if (raise) base_on = 1'b1;
         else acid_on = 1'b1;
      endfunction

      function void stop_pumps();
         raising  = 1'b0;
         lowering = 1'b0;
         acid_on  = 1'b0;
         base_on  = 1'b0;
      endfunction

      function void take_sample(int reading);
         int sp, half, cnt;
         longint sl, num, q;
         sp   = set_cfg;
         half = window_cfg >> 1;
         cnt  = (avg_cfg == 0) ? 1 : avg_cfg;
         // band check uses the pH left by the previous sample
         if (ph_now < sp - half) start_pump(1'b1);
         if (ph_now > sp + half) start_pump(1'b0);
         if (lowering && ph_now < sp) stop_pumps();
         if (raising && ph_now > sp) stop_pumps();
         if (reading != last_reading) begin
            sl  = (slope_cfg == 0) ? 1 : slope_cfg;
            num = (longint'(offset) - longint'(reading)) * (longint'(1) << PH_FRAC_BITS);
            q   = num / sl;
            if (q > 8191) q = 8191;
            if (q < -8192) q = -8192;
            ph_now = int'(q);
            reading_sum = reading_sum + SUM_BITS'(reading);
         end
         sample_count++;
         if (sample_count >= cnt) begin
            average      = (int'(reading_sum) / cnt) & READING_MAX;
            reading_sum  = '0;
            sample_count = 0;
         end
         last_reading = reading;
      endfunction

      function void note(op_type op, logic [READING_BITS-1:0] reading);
         dose_word_type w;
         longint b;
         case (op)
            OP_SAMPLE: take_sample(int'(reading));
            OP_TICK: begin
               if (lock_count >= lock_ticks_cfg && !expired) expired = 1'b1;
               else if (lock_count < LOCK_CEILING) lock_count++;
            end
            OP_CALIBRATE: begin
               b = ((longint'(cal_cfg) * slope_cfg) >> 8) + average;
               offset = (b > 65535) ? 65535 : int'(b);
            end
            default: ;
         endcase
         w.ph     = PH_BITS'(ph_now);
         w.acid   = acid_on;
         w.base   = base_on;
         w.mode   = raising ? MODE_RAISE : (lowering ? MODE_LOWER : MODE_IDLE);
         w.lock   = !expired;
         w.avg    = READING_BITS'(average);
         w.offset = OFFSET_BITS'(offset);
         due.push_back(w);
      endfunction

      function int pending();
         return due.size();
      endfunction

      task report(string msg);
         $display("%0t ERROR: %s", $time, msg);
         errors++;
      endtask

      task check(dose_word_type got);
         dose_word_type want;
         if (due.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         want = due.pop_front();
         if (got.ph !== want.ph)
            report($sformatf("ph_value got %0d expected %0d", got.ph, want.ph));
         if (got.acid !== want.acid)
            report($sformatf("acid_pump got %0d expected %0d", got.acid, want.acid));
         if (got.base !== want.base)
            report($sformatf("base_pump got %0d expected %0d", got.base, want.base));
         if (got.mode !== want.mode)
            report($sformatf("dosing_mode got %0d expected %0d", got.mode, want.mode));
         if (got.lock !== want.lock)
            report($sformatf("lockout_active got %0d expected %0d", got.lock, want.lock));
         if (got.avg !== want.avg)
            report($sformatf("average_reading got %0d expected %0d", got.avg, want.avg));
         if (got.offset !== want.offset)
            report($sformatf("offset_now got %0d expected %0d", got.offset, want.offset));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_op = OP_NOP;
   logic [READING_BITS-1:0]   req_raw_reading = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [PH_BITS-1:0] rsp_ph_value;
   logic                      rsp_acid_pump;
   logic                      rsp_base_pump;
   logic [1:0]                rsp_dosing_mode;
   logic                      rsp_lockout_active;
   logic [READING_BITS-1:0]   rsp_average_reading;
   logic [OFFSET_BITS-1:0]    rsp_offset_now;

   dosing_scoreboard sb = new();
   int  rx_hold = 0;
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;

   ph_dosing_controller_top dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_raw_reading     (req_raw_reading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ph_value        (rsp_ph_value),
      .rsp_acid_pump       (rsp_acid_pump),
      .rsp_base_pump       (rsp_base_pump),
      .rsp_dosing_mode     (rsp_dosing_mode),
      .rsp_lockout_active  (rsp_lockout_active),
      .rsp_average_reading (rsp_average_reading),
      .rsp_offset_now      (rsp_offset_now)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task send_word(op_type op, logic [READING_BITS-1:0] reading);
      int gap;
      if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_raw_reading <= reading;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note(op, reading);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task put_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.write_reg(idx, data);
   endtask

   task write_settings(logic [15:0] bias, logic [15:0] slope, logic [15:0] cal,
                       logic [15:0] sp, logic [15:0] win, logic [15:0] lock,
                       logic [15:0] avg, bit stray);
      put_reg(CSR_BIAS_RESET, bias);
      put_reg(CSR_SLOPE, slope);
      put_reg(CSR_CAL_POINT, cal);
      put_reg(CSR_SET_POINT, sp);
      put_reg(CSR_WINDOW, win);
      put_reg(CSR_LOCKOUT_TICKS, lock);
      put_reg(CSR_AVG_COUNT, avg);
      if (stray) put_reg(CSR_UNUSED, 16'hFFFF);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // readings mostly land around the set point so the band logic gets exercised
   task run_random(int n, int hold_at, int pause_at);
      int k, sl, r_set, span, r;
      for (int i = 0; i < n; i++) begin
         if (i == hold_at) rx_hold = 300;
         if (i == pause_at) drain();
         k = $urandom_range(0, 99);
         if (k < 45) begin
            sl    = (sb.slope_cfg == 0) ? 1 : sb.slope_cfg;
            r_set = sb.offset - (sb.set_cfg * sl) / 256;
            span  = (sb.window_cfg * sl) / 256 + 40;
            r     = r_set - span + int'($urandom_range(0, 2 * span));
            if (r < 0) r = 0;
            if (r > READING_MAX) r = READING_MAX;
            send_word(OP_SAMPLE, READING_BITS'(r));
         end else if (k < 55) begin
            send_word(OP_SAMPLE, READING_BITS'(sb.last_reading));
         end else if (k < 63) begin
            send_word(OP_SAMPLE, READING_BITS'($urandom_range(0, READING_MAX)));
         end else if (k < 90) begin
            send_word(OP_TICK, READING_BITS'($urandom_range(0, READING_MAX)));
         end else if (k < 95) begin
            send_word(OP_CALIBRATE, READING_BITS'($urandom_range(0, READING_MAX)));
         end else begin
            send_word(OP_NOP, READING_BITS'($urandom_range(0, READING_MAX)));
         end
      end
      drain();
   endtask

   initial begin : sink
      int gap;
      dose_word_type got;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
         gap = rx_calm ? 0 : $urandom_range(0, 7);
         if (rx_hold > 0) begin
            gap     = rx_hold;
            rx_hold = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got.ph     = rsp_ph_value;
         got.acid   = rsp_acid_pump;
         got.base   = rsp_base_pump;
         got.mode   = rsp_dosing_mode;
         got.lock   = rsp_lockout_active;
         got.avg    = rsp_average_reading;
         got.offset = rsp_offset_now;
         sb.check(got);
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on settings: pump start, stop, unchanged reading, all opcodes
      send_word(OP_SAMPLE, 14'd0);
      send_word(OP_SAMPLE, 14'd0);
      send_word(OP_SAMPLE, 14'd16383);
      send_word(OP_SAMPLE, 14'd16383);
      send_word(OP_TICK, 14'd16383);
      send_word(OP_NOP, 14'd0);
      send_word(OP_CALIBRATE, 14'd0);
      send_word(OP_SAMPLE, 14'd2085);
      send_word(OP_SAMPLE, 14'd1);
      send_word(OP_SAMPLE, 14'd16382);
      send_word(OP_SAMPLE, 14'd8191);
      send_word(OP_SAMPLE, 14'd8192);
      send_word(OP_TICK, 14'd0);
      send_word(OP_TICK, 14'd0);
      send_word(OP_SAMPLE, 14'h2AAA);
      send_word(OP_SAMPLE, 14'h1555);
      send_word(OP_CALIBRATE, 14'h3FFF);
      send_word(OP_NOP, 14'h3FFF);
      send_word(OP_SAMPLE, 14'd2085);
      send_word(OP_SAMPLE, 14'd3000);
      drain();

      write_settings(16'd4695, 16'd450, 16'd1792, 16'd1485, 16'd128, 16'd2, 16'd4, 1'b1);
      run_random(117, 40, -1);
      write_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
      run_random(117, -1, -1);
      // wide writes get masked to the field width
      write_settings(16'hFFFF, 16'hFFFF, 16'hFE00, 16'hFE00, 16'hFC00, 16'hFFFF, 16'hFFFF,
                     1'b0);
      run_random(117, -1, -1);
      // zero slope and zero count, count dropped below the running count
      write_settings(16'd8000, 16'd0, 16'd2000, 16'd2000, 16'd300, 16'd3, 16'd0, 1'b1);
      run_random(117, 60, -1);
      write_settings(16'd12000, 16'd900, 16'd2000, 16'd2560, 16'd64, 16'd1, 16'd7, 1'b0);
      run_random(117, -1, 50);
      write_settings(16'd3000, 16'd300, 16'd1000, 16'd1000, 16'd511, 16'd5, 16'd3, 1'b0);
      run_random(117, -1, -1);

      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ph_dosing_controller_top test passed");
      end else begin
         $display("ph_dosing_controller_top test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("ph_dosing_controller_top test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/pdc_pkg.sv
design/pdc_div.sv
design/pdc_datapath.sv
design/pdc_ctrl.sv
design/ph_dosing_controller_top.sv
design/pdc_checker.sv
tb/tb_top.sv
